### rtl/cpts_pkg.sv
// cpts_pkg: request and response types and operation codes for the cue point table
// used by cue_point_table_search and its port checker; no dependencies
`default_nettype none

package cpts_pkg;

	localparam int unsigned POS_W = 32;

	localparam logic [2:0] OP_SET   = 3'd0;
	localparam logic [2:0] OP_UNSET = 3'd1;
	localparam logic [2:0] OP_GET   = 3'd2;
	localparam logic [2:0] OP_PREV  = 3'd3;
	localparam logic [2:0] OP_NEXT  = 3'd4;
	localparam logic [2:0] OP_CLEAR = 3'd5;

	typedef struct packed {
		logic [2:0]              req_type;
		logic [3:0]              label;
		logic signed [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic                    found;
		logic signed [POS_W-1:0] cue_position;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/cue_point_table_search.sv
// cue_point_table_search: labelled cue position table with previous/next search
// depends on cpts_pkg
//
// usage:
//   requests come in on req_valid/req_ready with req (req_type, label, position);
//   every request gives exactly one response on rsp_valid/rsp_ready with rsp
//   (found, cue_position). one request is worked on at a time.
//   positions live in a synchronous ram, valid marks in flops.
//   after accept, set, unset, clear and unused codes go straight to ST_FINISH;
//   get passes ST_GET_WAIT for its ram read, previous/next ST_SCAN and
//   ST_SCAN_END: the search reads one entry per cycle through the single ram
//   read port. ST_FINISH loads the response, and the next request can be
//   taken in the cycle after the response is loaded.
//   req_ready is high whenever no request is in progress, also while a response
//   still waits to be taken; a new request is accepted and worked on, and only
//   its own response waits for the output register to drain.
//   a stalled receiver holds the response; the block waits at the end of the
//   request until the output register is free.
//   reset clears all valid marks and control state; no clearing pass is needed,
//   the ram content is only read behind a set valid mark.
`default_nettype none

module cue_point_table_search import cpts_pkg::*; #(
	parameter int NUM_CUES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int IDX_W = (NUM_CUES > 1) ? $clog2(NUM_CUES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GET_WAIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	req_t                    req_q;
	logic [NUM_CUES-1:0]     valid_q;
	logic [IDX_W-1:0]        scan_q;
	logic                    found_q;
	logic signed [POS_W-1:0] best_q;
	logic                    cmp_vld_s1;
	logic [IDX_W-1:0]        cmp_idx_s1;
	logic signed [POS_W-1:0] rd_data_s1;
	logic signed [POS_W-1:0] cue_mem [NUM_CUES];

	logic                    req_fire;
	logic                    lab_ok;
	logic [IDX_W-1:0]        lab_idx;
	logic                    lab_ok_q;
	logic [IDX_W-1:0]        lab_idx_q;
	logic [IDX_W-1:0]        rd_addr;
	logic                    cand;
	logic                    better;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;

	assign lab_ok    = (32'(req.label) < NUM_CUES);
	assign lab_idx   = IDX_W'(req.label);
	assign lab_ok_q  = (32'(req_q.label) < NUM_CUES);
	assign lab_idx_q = IDX_W'(req_q.label);

	assign rd_addr = (state_q == ST_SCAN) ? scan_q : lab_idx;

	// compare stage of the search
	always_comb begin
		cand   = 1'b0;
		better = 1'b0;
		if (req_q.req_type == OP_PREV) begin
			cand   = valid_q[cmp_idx_s1] && ($signed(rd_data_s1) < $signed(req_q.position));
			better = !found_q || ($signed(rd_data_s1) > $signed(best_q));
		end else begin
			cand   = valid_q[cmp_idx_s1] && ($signed(rd_data_s1) > $signed(req_q.position));
			better = !found_q || ($signed(rd_data_s1) < $signed(best_q));
		end
	end

	// position ram
	always_ff @(posedge clk) begin
		if (req_fire && (req.req_type == OP_SET) && lab_ok) begin
			cue_mem[lab_idx] <= req.position;
		end
		rd_data_s1 <= cue_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			scan_q     <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			rsp_valid  <= 1'b0;
			rsp        <= '0;
			req_q      <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			cmp_idx_s1 <= scan_q;
			if (rsp_valid && rsp_ready && (state_q != ST_FINISH)) begin
				rsp_valid <= 1'b0;
			end
			if (cmp_vld_s1 && cand && better) begin
				found_q <= 1'b1;
				best_q  <= rd_data_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						req_q   <= req;
						found_q <= 1'b0;
						best_q  <= '0;
						scan_q  <= '0;
						case (req.req_type)
							OP_SET: begin
								if (lab_ok) begin
									valid_q[lab_idx] <= 1'b1;
								end
								state_q <= ST_FINISH;
							end
							OP_UNSET: begin
								if (lab_ok) begin
									valid_q[lab_idx] <= 1'b0;
								end
								state_q <= ST_FINISH;
							end
							OP_CLEAR: begin
								valid_q <= '0;
								state_q <= ST_FINISH;
							end
							OP_GET: begin
								state_q <= ST_GET_WAIT;
							end
							OP_PREV, OP_NEXT: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_GET_WAIT: begin
					if (lab_ok_q && valid_q[lab_idx_q]) begin
						found_q <= 1'b1;
						best_q  <= rd_data_s1;
					end
					state_q <= ST_FINISH;
				end
				ST_SCAN: begin
					if (scan_q == IDX_W'(NUM_CUES - 1)) begin
						state_q <= ST_SCAN_END;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_SCAN_END: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!rsp_valid || rsp_ready) begin
						rsp_valid        <= 1'b1;
						rsp.found        <= found_q;
						rsp.cue_position <= found_q ? best_q : '0;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/cpts_chk.sv
// cpts_chk: port-level checks for cue_point_table_search, bound to the top level
// depends on cpts_pkg
`default_nettype none

module cpts_chk import cpts_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// response held while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	// no position without a hit
	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.cue_position == '0)
		else $error("nonzero position on a miss");

	// one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// a new response only comes at the end of a request
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response without a request in progress");

endmodule

bind cue_point_table_search cpts_chk u_cpts_chk (.*);

`default_nettype wire
